>>> rtl/core/rbe_pkg.sv
// Shared types, codes and Q-format arithmetic helpers for the quadrilateral basis evaluator.
// No dependencies; every other file in rtl/core except rbe_pipe imports this package.
package rbe_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned DIV_BITS = 4;

  // Reference-square targets per vertex row: xi for bit i, eta for bit i.
  localparam logic [3:0] TARGET_XI  = 4'b0110;
  localparam logic [3:0] TARGET_ETA = 4'b1100;

  typedef logic signed [QW-1:0]   q_t;
  typedef logic signed [QW:0]     sum_t;
  typedef logic signed [2*QW-1:0] prod_t;
  typedef logic signed [2*QW:0]   wide_t;

  localparam q_t QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t QMIN = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_VAL_L1  = 3'd0,
    CMD_VAL_L2  = 3'd1,
    CMD_VAL_L3  = 3'd2,
    CMD_VAL_L4  = 3'd3,
    CMD_GRAD_L1 = 3'd4,
    CMD_GRAD_L2 = 3'd5,
    CMD_GRAD_L3 = 3'd6,
    CMD_GRAD_L4 = 3'd7
  } cmd_e;

  typedef struct packed {
    logic            vld;
    logic            bad;
    cmd_e            cmd;
    q_t              px;
    q_t              py;
    q_t [3:0][3:0]   m;
    q_t [3:0][1:0]   a;
  } sys_t;

  typedef struct packed {
    logic vld;
    logic singular;
    q_t   a;
    q_t   b;
    q_t   c;
    q_t   d;
  } res_t;

  function automatic int unsigned div_latency(int unsigned frac);
    return (QW + frac + DIV_BITS - 1) / DIV_BITS + 2;
  endfunction

  function automatic q_t q_sat_sum(sum_t x);
    if (x[QW] != x[QW-1]) begin
      return x[QW] ? QMIN : QMAX;
    end
    return x[QW-1:0];
  endfunction

  function automatic q_t q_sat_wide(wide_t x);
    if ((&x[2*QW:QW-1]) || !(|x[2*QW:QW-1])) begin
      return x[QW-1:0];
    end
    return x[2*QW] ? QMIN : QMAX;
  endfunction

  function automatic q_t q_add(q_t a, q_t b);
    return q_sat_sum(sum_t'(a) + sum_t'(b));
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    return q_sat_sum(sum_t'(a) - sum_t'(b));
  endfunction

  function automatic q_t q_neg(q_t a);
    return q_sat_sum(sum_t'(0) - sum_t'(a));
  endfunction

  function automatic prod_t q_mul(q_t a, q_t b);
    return a * b;
  endfunction

  function automatic q_t q_round(prod_t p, int unsigned frac);
    wide_t t;
    t = wide_t'(p) + (wide_t'(1) <<< (frac - 1));
    t = t >>> frac;
    return q_sat_wide(t);
  endfunction

  function automatic logic [QW:0] q_mag(q_t x);
    sum_t e;
    e = sum_t'(x);
    return x[QW-1] ? unsigned'(-e) : unsigned'(e);
  endfunction

endpackage

>>> rtl/core/rt0_rectangle_basis_eval.sv
// Top level of the quadrilateral lowest-order basis evaluator: matrix setup, pipeline control.
// Depends on rbe_pkg, rbe_elim, rbe_back and rbe_eval.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | cmd_i, vertex_{x,y}{0..3}_i, point_{x,y}_i
//   out     | output    | out_valid_o / out_ready_i| out_a_o..out_d_o, singular_o
//
// One item per cycle while the output is not stalled.
// The latency is set by the chain of seven dependent pipelined dividers (three pivot columns,
// four back-substitution rows), each resolving four quotient bits per stage.
// Reset clears the valid bits of every stage; there is no clearing pass.
// A stalled output holds the whole pipeline in place; no transfer is lost or repeated.
module rt0_rectangle_basis_eval import rbe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic signed [31:0] vertex_x0_i,
  input  logic signed [31:0] vertex_y0_i,
  input  logic signed [31:0] vertex_x1_i,
  input  logic signed [31:0] vertex_y1_i,
  input  logic signed [31:0] vertex_x2_i,
  input  logic signed [31:0] vertex_y2_i,
  input  logic signed [31:0] vertex_x3_i,
  input  logic signed [31:0] vertex_y3_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [31:0] out_a_o,
  output logic signed [31:0] out_b_o,
  output logic signed [31:0] out_c_o,
  output logic signed [31:0] out_d_o,
  output logic              singular_o
);

  localparam q_t QOne = q_t'(1 << FRAC_BITS);

  logic  en;
  q_t    vx [4];
  q_t    vy [4];
  sys_t  sa_d, sa_q, sb_d, sb_q;
  prod_t vp_q [4];
  sys_t  elim_sys [4];
  sys_t  back_sys [5];
  res_t  res;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign vx[0] = vertex_x0_i;
  assign vy[0] = vertex_y0_i;
  assign vx[1] = vertex_x1_i;
  assign vy[1] = vertex_y1_i;
  assign vx[2] = vertex_x2_i;
  assign vy[2] = vertex_y2_i;
  assign vx[3] = vertex_x3_i;
  assign vy[3] = vertex_y3_i;

  always_comb begin
    sa_d     = '0;
    sa_d.vld = in_valid_i;
    sa_d.cmd = cmd_e'(cmd_i);
    sa_d.px  = point_x_i;
    sa_d.py  = point_y_i;
    for (int i = 0; i < 4; i++) begin
      sa_d.m[i][0] = QOne;
      sa_d.m[i][1] = vx[i];
      sa_d.m[i][2] = vy[i];
      sa_d.a[i][0] = TARGET_XI[i] ? QOne : '0;
      sa_d.a[i][1] = TARGET_ETA[i] ? QOne : '0;
    end
  end

  always_comb begin
    sb_d = sa_q;
    for (int i = 0; i < 4; i++) sb_d.m[i][3] = q_round(vp_q[i], FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
      sb_q <= '0;
    end else if (en) begin
      sa_q <= sa_d;
      sb_q <= sb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) vp_q[i] <= q_mul(vx[i], vy[i]);
    end
  end

  assign elim_sys[0] = sb_q;

  for (genvar g = 0; g < 3; g++) begin : g_elim
    rbe_elim #(.COL(g), .FRAC_BITS(FRAC_BITS)) u_elim (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sys_i  (elim_sys[g]),
      .sys_o  (elim_sys[g+1])
    );
  end

  assign back_sys[0] = elim_sys[3];

  for (genvar g = 0; g < 4; g++) begin : g_back
    rbe_back #(.ROW(3 - g), .FRAC_BITS(FRAC_BITS)) u_back (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sys_i  (back_sys[g]),
      .sys_o  (back_sys[g+1])
    );
  end

  rbe_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .sys_i  (back_sys[4]),
    .res_o  (res)
  );

  assign out_valid_o = res.vld;
  assign out_a_o     = res.a;
  assign out_b_o     = res.b;
  assign out_c_o     = res.c;
  assign out_d_o     = res.d;
  assign singular_o  = res.singular;

`ifndef NO_ASSERTIONS
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |->
      (out_a_o == 0 && out_b_o == 0 && out_c_o == 0 && out_d_o == 0))
    else $error("singular result carries nonzero outputs");

  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((out_a_o != 0 || out_c_o != 0) && (out_b_o != 0 || out_d_o != 0)))
    else $error("both vector components nonzero");

  a_rise_after_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("output became valid while pipeline was held");
`endif

endmodule

>>> rtl/core/rbe_pipe.sv
// Delay line with reset and a shared advance enable, for any payload type.
// No package dependency.
module rbe_pipe #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  T     d_i,
  output T     q_o
);

  T tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) tap_q[i] <= T'('0);
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

>>> rtl/core/rbe_qdiv.sv
// Pipelined signed Q-format divider, rounding half away from zero, saturating.
// Depends on rbe_pkg.
module rbe_qdiv import rbe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic en_i,
  input  q_t   num_i,
  input  q_t   den_i,
  output q_t   quo_o
);

  localparam int unsigned NW = QW + FRAC_BITS;
  localparam int unsigned NS = (NW + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned NP = NS * DIV_BITS;

  logic [NP-1:0] n_q   [NS+1];
  logic [QW-1:0] d_q   [NS+1];
  logic [QW-1:0] r_q   [NS+1];
  logic [QW:0]   qt_q  [NS+1];
  logic          ov_q  [NS+1];
  logic          neg_q [NS+1];

  logic [QW-1:0] an, ad;
  logic [QW:0]   lim, mag, nmag;
  logic          over;
  q_t            quo_d, quo_q;

  always_comb begin
    an = num_i[QW-1] ? unsigned'(-num_i) : unsigned'(num_i);
    ad = den_i[QW-1] ? unsigned'(-den_i) : unsigned'(den_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= (NP'(an) << FRAC_BITS) + NP'(ad >> 1);
      d_q[0]   <= ad;
      r_q[0]   <= '0;
      qt_q[0]  <= '0;
      ov_q[0]  <= 1'b0;
      neg_q[0] <= num_i[QW-1] ^ den_i[QW-1];
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NP-1:0] n_d;
    logic [QW-1:0] r_d;
    logic [QW:0]   qt_d;
    logic [QW:0]   tr;
    logic          ov_d;

    always_comb begin
      n_d  = n_q[s];
      r_d  = r_q[s];
      qt_d = qt_q[s];
      ov_d = ov_q[s];
      tr   = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
        tr   = {r_d, n_d[NP-1]};
        n_d  = n_d << 1;
        ov_d = ov_d | qt_d[QW];
        if (tr >= {1'b0, d_q[s]}) begin
          tr   = tr - {1'b0, d_q[s]};
          qt_d = {qt_d[QW-1:0], 1'b1};
        end else begin
          qt_d = {qt_d[QW-1:0], 1'b0};
        end
        r_d = tr[QW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1]   <= n_d;
        d_q[s+1]   <= d_q[s];
        r_q[s+1]   <= r_d;
        qt_q[s+1]  <= qt_d;
        ov_q[s+1]  <= ov_d;
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  always_comb begin
    lim  = {2'b01, {(QW-1){1'b0}}};
    over = ov_q[NS] || (qt_q[NS] > lim);
    mag  = over ? lim : qt_q[NS];
    nmag = -mag;
    if (d_q[NS] == '0) begin
      quo_d = '0;
    end else if (neg_q[NS]) begin
      quo_d = nmag[QW-1:0];
    end else if (mag == lim) begin
      quo_d = QMAX;
    end else begin
      quo_d = mag[QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

>>> rtl/core/rbe_elim.sv
// One elimination column: pivot search and row swap, divide, multiply, subtract.
// Depends on rbe_pkg, rbe_qdiv and rbe_pipe.
module rbe_elim import rbe_pkg::*; #(
  parameter int unsigned COL       = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  sys_t sys_i,
  output sys_t sys_o
);

  localparam int unsigned DivLat = div_latency(FRAC_BITS);
  localparam int unsigned NR     = 3 - COL;

  sys_t        piv_d, piv_q, dly_sys, mul_q, sub_d, sub_q;
  logic [1:0]  sel;
  logic [QW:0] best;
  q_t          quo  [NR];
  prod_t       pm_q [NR][NR];
  prod_t       pa_q [NR][2];

  always_comb begin
    sel  = 2'(COL);
    best = q_mag(sys_i.m[COL][COL]);
    for (int j = COL + 1; j < 4; j++) begin
      if (q_mag(sys_i.m[j][COL]) > best) begin
        sel  = 2'(j);
        best = q_mag(sys_i.m[j][COL]);
      end
    end
    piv_d        = sys_i;
    piv_d.m[COL] = sys_i.m[sel];
    piv_d.m[sel] = sys_i.m[COL];
    piv_d.a[COL] = sys_i.a[sel];
    piv_d.a[sel] = sys_i.a[COL];
    if (sys_i.m[sel][COL] == '0) piv_d.bad = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piv_q <= '0;
      mul_q <= '0;
      sub_q <= '0;
    end else if (en_i) begin
      piv_q <= piv_d;
      mul_q <= dly_sys;
      sub_q <= sub_d;
    end
  end

  for (genvar j = 0; j < NR; j++) begin : g_div
    rbe_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (piv_q.m[COL+1+j][COL]),
      .den_i (piv_q.m[COL][COL]),
      .quo_o (quo[j])
    );
  end

  rbe_pipe #(.T(sys_t), .DEPTH(DivLat)) u_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (piv_q),
    .q_o    (dly_sys)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NR; j++) begin
        for (int k = 0; k < NR; k++) pm_q[j][k] <= q_mul(quo[j], dly_sys.m[COL][COL+1+k]);
        for (int c = 0; c < 2; c++) pa_q[j][c] <= q_mul(quo[j], dly_sys.a[COL][c]);
      end
    end
  end

  always_comb begin
    sub_d = mul_q;
    for (int j = 0; j < NR; j++) begin
      for (int k = 0; k < NR; k++) begin
        sub_d.m[COL+1+j][COL+1+k] = q_sub(mul_q.m[COL+1+j][COL+1+k],
                                          q_round(pm_q[j][k], FRAC_BITS));
      end
      for (int c = 0; c < 2; c++) begin
        sub_d.a[COL+1+j][c] = q_sub(mul_q.a[COL+1+j][c], q_round(pa_q[j][c], FRAC_BITS));
      end
    end
  end

  assign sys_o = sub_q;

endmodule

>>> rtl/core/rbe_back.sv
// One back-substitution row: ordered multiply-subtract steps, then divide by the diagonal.
// Depends on rbe_pkg, rbe_qdiv and rbe_pipe.
module rbe_back import rbe_pkg::*; #(
  parameter int unsigned ROW       = 3,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  sys_t sys_i,
  output sys_t sys_o
);

  localparam int unsigned DivLat = div_latency(FRAC_BITS);
  localparam int unsigned NJ     = 3 - ROW;

  sys_t head;
  sys_t chain [NJ+1];
  sys_t dly_sys;
  q_t   quo   [2];

  always_comb begin
    head = sys_i;
    if (ROW == 3 && sys_i.m[3][3] == '0) head.bad = 1'b1;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < NJ; g++) begin : g_step
    sys_t  ms_q, ss_d, ss_q;
    prod_t p_q [2];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ms_q <= '0;
        ss_q <= '0;
      end else if (en_i) begin
        ms_q <= chain[g];
        ss_q <= ss_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int c = 0; c < 2; c++) p_q[c] <= q_mul(chain[g].m[ROW][ROW+1+g], chain[g].a[ROW+1+g][c]);
      end
    end

    always_comb begin
      ss_d = ms_q;
      for (int c = 0; c < 2; c++) ss_d.a[ROW][c] = q_sub(ms_q.a[ROW][c], q_round(p_q[c], FRAC_BITS));
    end

    assign chain[g+1] = ss_q;
  end

  for (genvar c = 0; c < 2; c++) begin : g_div
    rbe_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (chain[NJ].a[ROW][c]),
      .den_i (chain[NJ].m[ROW][ROW]),
      .quo_o (quo[c])
    );
  end

  rbe_pipe #(.T(sys_t), .DEPTH(DivLat)) u_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (chain[NJ]),
    .q_o    (dly_sys)
  );

  always_comb begin
    sys_o = dly_sys;
    for (int c = 0; c < 2; c++) sys_o.a[ROW][c] = quo[c];
  end

endmodule

>>> rtl/core/rbe_eval.sv
// Evaluates xi, eta and the gradient terms at the point, then selects the result.
// Depends on rbe_pkg.
module rbe_eval import rbe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  sys_t sys_i,
  output res_t res_o
);

  typedef struct packed {
    logic vld;
    logic bad;
    cmd_e cmd;
  } ctl_t;

  localparam q_t QOne = q_t'(1 << FRAC_BITS);

  ctl_t  c1_q, c2_q, c3_q, c4_q;
  sys_t  s1_q;
  prod_t pr_q [2][4];
  q_t    x0_q [2], r2_q [2], r3x_q [2], g0_q [2], g1_q [2];
  q_t    x1_q [2], g0b_q [2], g1b_q [2];
  q_t    v_q  [2], g0c_q [2], g1c_q [2];
  prod_t pt_q [2];
  q_t    py2_q;
  res_t  res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q  <= '0;
      c2_q  <= '0;
      c3_q  <= '0;
      c4_q  <= '0;
      res_q <= '0;
    end else if (en_i) begin
      c1_q  <= '{vld: sys_i.vld, bad: sys_i.bad, cmd: sys_i.cmd};
      c2_q  <= c1_q;
      c3_q  <= c2_q;
      c4_q  <= c3_q;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= sys_i;
      for (int c = 0; c < 2; c++) begin
        pr_q[c][0] <= q_mul(sys_i.a[1][c], sys_i.px);
        pr_q[c][1] <= q_mul(sys_i.a[2][c], sys_i.py);
        pr_q[c][2] <= q_mul(sys_i.a[3][c], sys_i.px);
        pr_q[c][3] <= q_mul(sys_i.a[3][c], sys_i.py);
      end
      py2_q <= s1_q.py;
      for (int c = 0; c < 2; c++) begin
        x0_q[c]  <= q_add(s1_q.a[0][c], q_round(pr_q[c][0], FRAC_BITS));
        r2_q[c]  <= q_round(pr_q[c][1], FRAC_BITS);
        r3x_q[c] <= q_round(pr_q[c][2], FRAC_BITS);
        g0_q[c]  <= q_add(s1_q.a[1][c], q_round(pr_q[c][3], FRAC_BITS));
        g1_q[c]  <= q_add(s1_q.a[2][c], q_round(pr_q[c][2], FRAC_BITS));
        pt_q[c]  <= q_mul(r3x_q[c], py2_q);
        x1_q[c]  <= q_add(x0_q[c], r2_q[c]);
        g0b_q[c] <= g0_q[c];
        g1b_q[c] <= g1_q[c];
        v_q[c]   <= q_add(x1_q[c], q_round(pt_q[c], FRAC_BITS));
        g0c_q[c] <= g0b_q[c];
        g1c_q[c] <= g1b_q[c];
      end
    end
  end

  always_comb begin
    res_d          = '0;
    res_d.vld      = c4_q.vld;
    res_d.singular = c4_q.bad;
    if (!c4_q.bad) begin
      unique case (c4_q.cmd)
        CMD_VAL_L1: res_d.b = q_sub(QOne, v_q[1]);
        CMD_VAL_L2: res_d.a = v_q[0];
        CMD_VAL_L3: res_d.b = v_q[1];
        CMD_VAL_L4: res_d.a = q_sub(QOne, v_q[0]);
        CMD_GRAD_L1: begin
          res_d.b = q_neg(g0c_q[1]);
          res_d.d = q_neg(g1c_q[1]);
        end
        CMD_GRAD_L2: begin
          res_d.a = g0c_q[0];
          res_d.c = g1c_q[0];
        end
        CMD_GRAD_L3: begin
          res_d.b = g0c_q[1];
          res_d.d = g1c_q[1];
        end
        default: begin
          res_d.a = q_neg(g0c_q[0]);
          res_d.c = q_neg(g1c_q[0]);
        end
      endcase
    end
  end

  assign res_o = res_q;

endmodule
